// ===== design/rabs_pkg.sv =====
// rabs_pkg: shared types and constants for the running-average background
// subtraction unit. No dependencies; used by scope in all but rabs_position.
package rabs_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic       start_of_frame;
  } in_t;

  typedef struct packed {
    logic [7:0] bg_chan0;
    logic [7:0] bg_chan1;
    logic [7:0] bg_chan2;
    logic       foreground;
  } out_t;

  // Per-stage load enables for the channel lanes
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q12          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS       = 2'd2;
  localparam int CFG_DATA_W = 17;

  // Field widths
  localparam int NUM_CHAN  = 3;
  localparam int BG_W      = 20;              // Q8.12 per channel
  localparam int ALPHA_W   = 13;
  localparam int THRESH_W  = 9;
  localparam int LIM_W     = 19;              // (threshold+1)^2 <= 512^2
  localparam int SQ_W      = 16;
  localparam int SUM_W     = 18;
  localparam int FRAME_CFG_W = 17;

  // Constants
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 13'd4096;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 13'd410;
  localparam logic [LIM_W-1:0]   LIM_RST    = 19'd961;   // (30+1)^2
  localparam int                 FRAME_RST  = 65536;
  localparam logic [BG_W-1:0]    BG_MAX     = 20'd1044480; // 255 * 4096
  localparam logic [BG_W:0]      BG_HALF    = 21'd2048;
  localparam logic [8:0]         BYTE_MAX   = 9'd255;

endpackage

// ===== design/running_average_background_subtract_unit.sv =====
// Running-average background subtraction. Pixels arrive in raster order, one
// transaction per pixel; each updates its own Q8.12 three-channel background
// entry by bg += floor(alpha*(pix*4096 - bg)/4096), returns the updated
// background rounded to bytes, and flags foreground when the squared color
// distance reaches (threshold+1)^2. Throughput is one pixel per clock unless
// the output stalls or the interlock or sweep holds the input. The store is a
// single memory with separate read and write ports and writeback three
// stages after the read, so a pixel whose position is still in flight in
// those stages (frames under four pixels, or a start of frame landing on a
// position used within the last three pixels) waits until that writeback is
// done. After reset a zeroing sweep clears every entry, during which no pixel
// is taken; configuration writes are accepted at any time. Depends on
// rabs_pkg and submodules rabs_bg_mem, rabs_position and rabs_lane.
module running_average_background_subtract_unit #(
  parameter int FRAME_PIXELS = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rabs_pkg::in_t                      in_data,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output rabs_pkg::out_t                     out_data,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [rabs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int ADDR_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int LEN_W   = $clog2(FRAME_PIXELS + 1);
  localparam int LEN_RST = (FRAME_PIXELS < rabs_pkg::FRAME_RST) ? FRAME_PIXELS
                                                                 : rabs_pkg::FRAME_RST;
  localparam int NCH     = rabs_pkg::NUM_CHAN;
  localparam int BG_W    = rabs_pkg::BG_W;

  // ---------------------------------------------------------------------------
  // Configuration: stored in the form the datapath uses (saturated alpha,
  // squared threshold limit, resolved frame length).
  // ---------------------------------------------------------------------------
  logic [rabs_pkg::ALPHA_W-1:0]     alpha_r;
  logic [rabs_pkg::LIM_W-1:0]       lim_r;
  logic [LEN_W-1:0]                 len_r;
  logic [rabs_pkg::ALPHA_W-1:0]     alpha_w;
  logic [rabs_pkg::THRESH_W:0]      thr_p1;
  logic [2*rabs_pkg::THRESH_W+1:0]  thr_sq;
  logic [rabs_pkg::FRAME_CFG_W-1:0] fp_w;
  logic                             fp_bad;

  assign alpha_w = cfg_wdata[rabs_pkg::ALPHA_W-1:0];
  assign thr_p1  = {1'b0, cfg_wdata[rabs_pkg::THRESH_W-1:0]} + 1'b1;
  assign thr_sq  = thr_p1 * thr_p1;
  assign fp_w    = cfg_wdata[rabs_pkg::FRAME_CFG_W-1:0];
  // zero or longer than the store falls back to the full store
  assign fp_bad  = (fp_w == '0) || (32'(fp_w) > 32'(FRAME_PIXELS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= rabs_pkg::ALPHA_RST;
      lim_r   <= rabs_pkg::LIM_RST;
      len_r   <= LEN_W'(LEN_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        rabs_pkg::CFG_ALPHA_Q12: begin
          alpha_r <= (alpha_w > rabs_pkg::ALPHA_ONE) ? rabs_pkg::ALPHA_ONE : alpha_w;
        end
        rabs_pkg::CFG_DISTANCE_THRESHOLD: begin
          lim_r <= thr_sq[rabs_pkg::LIM_W-1:0];
        end
        rabs_pkg::CFG_FRAME_PIXELS: begin
          len_r <= fp_bad ? LEN_W'(FRAME_PIXELS) : LEN_W'(fp_w);
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage loads when empty or when the stage after it
  // loads, so bubbles collapse; out_ready reaches in_ready through this chain.
  //   s1: memory read data   s2: difference   s3: product / writeback
  //   s4: byte               s5: squared distance   out: compare
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en_out;
  logic accept;
  logic hazard;
  logic clearing;
  rabs_pkg::pipe_en_t lane_en;

  assign en_out = !out_valid_r || out_ready;
  assign en5    = !v5_r || en_out;
  assign en4    = !v4_r || en5;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;

  assign lane_en.s2 = en2;
  assign lane_en.s3 = en3;
  assign lane_en.s4 = en4;
  assign lane_en.s5 = en5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= accept;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en5)    v5_r        <= v4_r;
      if (en_out) out_valid_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Position and read-after-write interlock: a pixel may not read its entry
  // while an earlier pixel at the same position has not yet written back.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] pos_in;
  logic [ADDR_W-1:0] pos1_r, pos2_r, pos3_r;
  rabs_pkg::in_t     in1_r;

  rabs_position #(
    .DEPTH (FRAME_PIXELS)
  ) u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .sof       (in_data.start_of_frame),
    .take      (accept),
    .frame_len (len_r),
    .pos       (pos_in)
  );

  assign hazard = (v1_r && (pos1_r == pos_in)) ||
                  (v2_r && (pos2_r == pos_in)) ||
                  (v3_r && (pos3_r == pos_in));

  assign in_ready = en1 && !clearing && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      in1_r  <= in_data;
      pos1_r <= pos_in;
    end
    if (en2) pos2_r <= pos1_r;
    if (en3) pos3_r <= pos2_r;
  end

  // ---------------------------------------------------------------------------
  // Background store: read on accept, write back when stage 3 moves on.
  // ---------------------------------------------------------------------------
  logic [NCH*BG_W-1:0] rd_word;
  logic [NCH*BG_W-1:0] wr_word;
  logic                wr_en;

  assign wr_en = v3_r && en4;

  rabs_bg_mem #(
    .DEPTH (FRAME_PIXELS)
  ) u_bg_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (pos_in),
    .rd_data  (rd_word),
    .wr_en    (wr_en),
    .wr_addr  (pos3_r),
    .wr_data  (wr_word),
    .clearing (clearing)
  );

  // ---------------------------------------------------------------------------
  // Channel lanes
  // ---------------------------------------------------------------------------
  logic [7:0]                pix1   [NCH];
  logic [BG_W-1:0]           nb     [NCH];
  logic [7:0]                bbyte  [NCH];
  logic [rabs_pkg::SQ_W-1:0] sq     [NCH];

  assign pix1[0] = in1_r.chan0;
  assign pix1[1] = in1_r.chan1;
  assign pix1[2] = in1_r.chan2;

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    rabs_lane u_lane (
      .clk     (clk),
      .en      (lane_en),
      .alpha   (alpha_r),
      .pix_in  (pix1[k]),
      .bg_in   (rd_word[k*BG_W +: BG_W]),
      .nb      (nb[k]),
      .bg_byte (bbyte[k]),
      .dist_sq (sq[k])
    );
    assign wr_word[k*BG_W +: BG_W] = nb[k];
  end

  // ---------------------------------------------------------------------------
  // Distance compare and output register
  // ---------------------------------------------------------------------------
  logic [rabs_pkg::SUM_W-1:0] dist_sum;
  rabs_pkg::out_t             out_data_r;

  assign dist_sum = rabs_pkg::SUM_W'(sq[0]) + rabs_pkg::SUM_W'(sq[1])
                  + rabs_pkg::SUM_W'(sq[2]);

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r.bg_chan0   <= bbyte[0];
      out_data_r.bg_chan1   <= bbyte[1];
      out_data_r.bg_chan2   <= bbyte[2];
      out_data_r.foreground <= (rabs_pkg::LIM_W'(dist_sum) >= lim_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a read never races a pending writeback to the same entry
  a_no_raw_race: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wr_en) |-> (pos_in != pos3_r))
    else $error("read of an entry during its own writeback");

  // no pixel enters while the store is being zeroed
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("pixel taken during clearing sweep");

  // writebacks only come from pixels taken after the sweep
  a_no_wb_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(v1_r || v2_r || v3_r))
    else $error("pipeline active during clearing sweep");

  // an item in stage 3 that cannot move keeps its place
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> (v3_r && $stable(pos3_r)))
    else $error("stalled writeback item lost");

endmodule

// ===== design/rabs_bg_mem.sv =====
// rabs_bg_mem: per-pixel Q8.12 background store, one write and one
// registered read port, with a zeroing sweep after reset. Uses rabs_pkg.
module rabs_bg_mem #(
  parameter int DEPTH = 65536
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [rabs_pkg::NUM_CHAN*rabs_pkg::BG_W-1:0] rd_data,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [rabs_pkg::NUM_CHAN*rabs_pkg::BG_W-1:0] wr_data,
  output logic                                        clearing
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = rabs_pkg::NUM_CHAN * rabs_pkg::BG_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [WORD_W-1:0] wd;

  // sweep owns the write port until every entry is zero
  assign we = clr_r | wr_en;
  assign wa = clr_r ? clr_addr_r : wr_addr;
  assign wd = clr_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

// ===== design/rabs_position.sv =====
// rabs_position: pixel position counter with start-of-frame restart and
// wrap at the programmed frame length. Does not use rabs_pkg.
module rabs_position #(
  parameter int DEPTH = 65536
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              sof,
  input  logic                                              take,
  input  logic [$clog2(DEPTH+1)-1:0]                         frame_len,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       pos
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(DEPTH + 1);

  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] cnt_nxt;
  logic [LEN_W-1:0]  pos_p1;

  // restart on frame start, or when the frame was shortened under us
  assign pos    = (sof || (LEN_W'(cnt_r) >= frame_len)) ? '0 : cnt_r;
  assign pos_p1 = LEN_W'(pos) + 1'b1;
  assign cnt_nxt = (pos_p1 >= frame_len) ? '0 : ADDR_W'(pos_p1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/rabs_lane.sv =====
// rabs_lane: one color channel of the update datapath: difference, alpha
// multiply, floor/clamp to Q8.12, byte rounding, squared distance. Uses rabs_pkg.
module rabs_lane (
  input  logic                              clk,
  input  rabs_pkg::pipe_en_t                en,
  input  logic [rabs_pkg::ALPHA_W-1:0]      alpha,
  input  logic [7:0]                        pix_in,
  input  logic [rabs_pkg::BG_W-1:0]         bg_in,
  output logic [rabs_pkg::BG_W-1:0]         nb,
  output logic [7:0]                        bg_byte,
  output logic [rabs_pkg::SQ_W-1:0]         dist_sq
);

  localparam int BG_W = rabs_pkg::BG_W;

  // stage 2
  logic [7:0]             pix2_r;
  logic [BG_W-1:0]        bg2_r;
  logic signed [BG_W:0]   diff2_r;
  logic signed [BG_W:0]   diff_nxt;
  // stage 3
  logic [7:0]             pix3_r;
  logic [BG_W-1:0]        bg3_r;
  logic signed [32:0]     prod3_r;
  logic signed [34:0]     prod_full;
  // writeback math
  logic signed [BG_W:0]   step;
  logic signed [BG_W+1:0] nb_sum;
  logic [BG_W:0]          rnd;
  logic [8:0]             b9;
  logic [7:0]             byte_nxt;
  // stage 4
  logic [7:0]             pix4_r;
  logic [7:0]             byte4_r;
  logic [7:0]             absd;
  // stage 5
  logic [7:0]             byte5_r;
  logic [rabs_pkg::SQ_W-1:0] sq5_r;

  assign diff_nxt  = $signed({1'b0, pix_in, 12'h000}) - $signed({1'b0, bg_in});
  assign prod_full = $signed({1'b0, alpha}) * diff2_r;

  // arithmetic shift gives floor for both signs
  assign step   = prod3_r[32:12];
  assign nb_sum = $signed({2'b00, bg3_r}) + $signed({step[BG_W], step});

  always_comb begin
    if (nb_sum[BG_W+1]) begin
      nb = '0;
    end else if (nb_sum[BG_W:0] > {1'b0, rabs_pkg::BG_MAX}) begin
      nb = rabs_pkg::BG_MAX;
    end else begin
      nb = nb_sum[BG_W-1:0];
    end
  end

  assign rnd      = {1'b0, nb} + rabs_pkg::BG_HALF;
  assign b9       = rnd[BG_W:12];
  assign byte_nxt = (b9 > rabs_pkg::BYTE_MAX) ? 8'hFF : b9[7:0];

  assign absd = (pix4_r >= byte4_r) ? (pix4_r - byte4_r) : (byte4_r - pix4_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pix2_r  <= pix_in;
      bg2_r   <= bg_in;
      diff2_r <= diff_nxt;
    end
    if (en.s3) begin
      pix3_r  <= pix2_r;
      bg3_r   <= bg2_r;
      prod3_r <= prod_full[32:0];
    end
    if (en.s4) begin
      pix4_r  <= pix3_r;
      byte4_r <= byte_nxt;
    end
    if (en.s5) begin
      byte5_r <= byte4_r;
      sq5_r   <= absd * absd;
    end
  end

  assign bg_byte = byte5_r;
  assign dist_sq = sq5_r;

endmodule
